@@ sv/frc_pkg.sv @@
// frc_pkg: shared constants, codes and controller/datapath interface types
// for the frustum cull classifier; depends on nothing
package frc_pkg;

    localparam int PLANE_COUNT = 6;
    localparam int PLANE_IW    = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
    localparam int AXIS_COUNT  = 3;
    localparam int COMP_W      = 32;
    localparam int PROD_W      = 64;
    localparam int WIDE_W      = 68;

    typedef enum logic [2:0] {
        FN_LOAD_PLANE = 3'd0,
        FN_POINT      = 3'd1,
        FN_SPHERE     = 3'd2,
        FN_LOAD_AXIS  = 3'd3,
        FN_BOX        = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        POS_FRONT    = 2'd0,
        POS_BACK     = 2'd1,
        POS_ONPLANE  = 2'd2,
        POS_SPANNING = 2'd3
    } t_pos;

    typedef enum logic [2:0] {
        K_POINT,
        K_SPHERE,
        K_AXIS,
        K_CENTER,
        K_AXLOAD
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT
    } t_state;

    typedef struct packed {
        logic                capture;
        logic                issue;
        logic                flush;
        t_kind               kind;
        logic [PLANE_IW-1:0] plane;
        logic [1:0]          axis;
        logic                last;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic empty;
        t_pos position;
    } t_status;

    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [1:0] axis;
        logic       last;
    } t_tag;

endpackage

@@ sv/frc_ctrl.sv @@
// frc_ctrl: job sequencer, issues one dot product per cycle to the datapath
// depends on frc_pkg
module frc_ctrl
    import frc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic [2:0] i_func,
    input  logic [2:0] i_slot,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy,
    output logic    o_done,
    output logic [1:0] o_position
);

    localparam logic [PLANE_IW-1:0] LAST_PLANE = PLANE_IW'(PLANE_COUNT - 1);

    t_state              r_state, n_state;
    t_kind               r_mode, n_mode;
    logic [PLANE_IW-1:0] r_plane, n_plane;
    logic [1:0]          r_axis, n_axis;
    logic                r_done;
    t_pos                r_position;
    logic                accept;
    logic                job_go;
    logic                last_issue;
    t_kind               start_mode;

    assign o_busy     = (r_state != S_IDLE);
    assign accept     = i_start && !o_busy;
    assign o_done     = r_done;
    assign o_position = r_position;

    // decode of the accepted word
    always_comb begin
        job_go     = 1'b0;
        start_mode = K_POINT;
        unique case (t_func'(i_func))
            FN_POINT: begin
                job_go = 1'b1;
            end
            FN_SPHERE: begin
                job_go     = 1'b1;
                start_mode = K_SPHERE;
            end
            FN_BOX: begin
                job_go     = 1'b1;
                start_mode = K_AXIS;
            end
            FN_LOAD_AXIS: begin
                job_go     = (i_slot < 3'(AXIS_COUNT));
                start_mode = K_AXLOAD;
            end
            default: begin
                job_go = 1'b0;
            end
        endcase
    end

    assign last_issue = (r_mode == K_AXLOAD) ||
                        ((r_plane == LAST_PLANE) && ((r_mode != K_AXIS) || (r_axis == 2'd3)));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && job_go) n_state = S_ISSUE;
            end
            S_ISSUE: begin
                if (i_status.done) n_state = S_IDLE;
                else if (last_issue) n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_status.done || i_status.empty) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands and counters
    always_comb begin
        o_cmd         = '0;
        o_cmd.kind    = K_POINT;
        n_mode        = r_mode;
        n_plane       = r_plane;
        n_axis        = r_axis;
        o_cmd.capture = accept;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_mode  = start_mode;
                    n_plane = '0;
                    n_axis  = (start_mode == K_AXLOAD) ? i_slot[1:0] : 2'd0;
                end
            end
            S_ISSUE: begin
                o_cmd.flush = i_status.done;
                if (!i_status.done) begin
                    o_cmd.issue = 1'b1;
                    o_cmd.plane = r_plane;
                    o_cmd.axis  = r_axis;
                    o_cmd.last  = (r_plane == LAST_PLANE);
                    if (r_mode == K_AXIS) begin
                        o_cmd.kind = (r_axis == 2'd3) ? K_CENTER : K_AXIS;
                        if (r_axis == 2'd3) begin
                            n_axis  = 2'd0;
                            n_plane = r_plane + 1'b1;
                        end else begin
                            n_axis = r_axis + 2'd1;
                        end
                    end else begin
                        o_cmd.kind = r_mode;
                        n_plane    = r_plane + 1'b1;
                    end
                end
            end
            S_WAIT: begin
                o_cmd.flush = i_status.done;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= i_status.done && (r_state != S_IDLE);
        end
        r_mode     <= n_mode;
        r_plane    <= n_plane;
        r_axis     <= n_axis;
        r_position <= i_status.position;
    end

endmodule

@@ sv/frc_dp.sv @@
// frc_dp: plane and half-axis stores, four-lane dot product unit,
// radius accumulator and per-plane decision; depends on frc_pkg
module frc_dp
    import frc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic [2:0]               i_func,
    input  logic [2:0]               i_slot,
    input  logic signed [COMP_W-1:0] i_px,
    input  logic signed [COMP_W-1:0] i_py,
    input  logic signed [COMP_W-1:0] i_pz,
    input  logic signed [COMP_W-1:0] i_pw,
    output t_status                  o_status
);

    localparam logic signed [COMP_W-1:0] ONE_Q16 = COMP_W'(65536);

    logic signed [COMP_W-1:0] plane_store [PLANE_COUNT][4];
    logic signed [COMP_W-1:0] half_axis [AXIS_COUNT][3];

    logic signed [COMP_W-1:0] r_x, r_y, r_z, r_w;
    logic signed [COMP_W-1:0] coef [4];
    logic signed [COMP_W-1:0] vec [4];
    logic signed [PROD_W-1:0] r_prod [4];
    logic signed [WIDE_W-1:0] r_dot, r_rad;
    logic signed [WIDE_W-1:0] dot_abs, sph_sum;
    t_tag                     r_tag1, r_tag2;
    logic [PLANE_IW+2:0]      slot_ext;
    logic                     dot_zero, dot_neg;

    function automatic logic signed [COMP_W-1:0] sat_round(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W:0] t;
        logic signed [PROD_W-16:0] s;
        t = (PROD_W+1)'(p) + (PROD_W+1)'(32768);
        s = $signed(t[PROD_W:16]);
        if (s > (PROD_W-15)'(64'sh7fffffff)) return 32'sh7fffffff;
        if (s < -(PROD_W-15)'(64'sh80000000)) return 32'sh80000000;
        return s[COMP_W-1:0];
    endfunction

    assign slot_ext = (PLANE_IW+3)'(i_slot);

    // operand select for the four multiplier lanes
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            coef[i] = plane_store[i_cmd.plane][i];
        end
        vec[0] = r_x;
        vec[1] = r_y;
        vec[2] = r_z;
        vec[3] = ONE_Q16;
        unique case (i_cmd.kind)
            K_AXIS: begin
                for (int i = 0; i < 3; i++) begin
                    vec[i] = half_axis[i_cmd.axis][i];
                end
                vec[3] = '0;
            end
            K_AXLOAD: begin
                for (int i = 0; i < 3; i++) begin
                    coef[i] = r_w;
                end
                coef[3] = '0;
                vec[3]  = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x <= i_px;
            r_y <= i_py;
            r_z <= i_pz;
            r_w <= i_pw;
            if ((t_func'(i_func) == FN_LOAD_PLANE) && (slot_ext < (PLANE_IW+3)'(PLANE_COUNT))) begin
                plane_store[slot_ext[PLANE_IW-1:0]][0] <= i_px;
                plane_store[slot_ext[PLANE_IW-1:0]][1] <= i_py;
                plane_store[slot_ext[PLANE_IW-1:0]][2] <= i_pz;
                plane_store[slot_ext[PLANE_IW-1:0]][3] <= i_pw;
            end
        end
        if (i_cmd.issue) begin
            for (int i = 0; i < 4; i++) begin
                r_prod[i] <= coef[i] * vec[i];
            end
        end
        if (r_tag1.valid && (r_tag1.kind == K_AXLOAD)) begin
            for (int i = 0; i < 3; i++) begin
                half_axis[r_tag1.axis][i] <= sat_round(r_prod[i]);
            end
        end
        r_dot <= WIDE_W'(r_prod[0]) + WIDE_W'(r_prod[1])
               + WIDE_W'(r_prod[2]) + WIDE_W'(r_prod[3]);
        if (r_tag2.valid && (r_tag2.kind == K_AXIS)) begin
            r_rad <= (r_tag2.axis == 2'd0) ? dot_abs : r_rad + dot_abs;
        end
    end

    // tag pipeline follows the products and sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.flush) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
        end else begin
            r_tag1 <= '{valid: i_cmd.issue, kind: i_cmd.kind, axis: i_cmd.axis,
                        last: i_cmd.last};
            r_tag2 <= r_tag1;
        end
    end

    assign dot_zero = (r_dot == '0);
    assign dot_neg  = r_dot[WIDE_W-1];
    assign dot_abs  = dot_neg ? -r_dot : r_dot;
    assign sph_sum  = r_dot + (WIDE_W'(r_w) <<< 16);

    // per-plane decision with early exit
    always_comb begin
        o_status          = '0;
        o_status.position = POS_FRONT;
        o_status.empty    = !r_tag1.valid && !r_tag2.valid;
        if (r_tag2.valid) begin
            unique case (r_tag2.kind)
                K_POINT: begin
                    if (dot_zero) begin
                        o_status.done     = 1'b1;
                        o_status.position = POS_ONPLANE;
                    end else if (dot_neg) begin
                        o_status.done     = 1'b1;
                        o_status.position = POS_FRONT;
                    end else if (r_tag2.last) begin
                        o_status.done     = 1'b1;
                        o_status.position = POS_BACK;
                    end
                end
                K_SPHERE: begin
                    if (sph_sum[WIDE_W-1] || (sph_sum == '0)) begin
                        o_status.done     = 1'b1;
                        o_status.position = POS_FRONT;
                    end else if (r_tag2.last) begin
                        o_status.done     = 1'b1;
                        o_status.position = POS_BACK;
                    end
                end
                K_CENTER: begin
                    if (dot_neg) begin
                        o_status.done     = 1'b1;
                        o_status.position = (r_dot > -r_rad) ? POS_SPANNING : POS_BACK;
                    end else if (!dot_zero && (r_dot < r_rad)) begin
                        o_status.done     = 1'b1;
                        o_status.position = POS_SPANNING;
                    end else if (r_tag2.last) begin
                        o_status.done     = 1'b1;
                        o_status.position = POS_FRONT;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

@@ sv/frustum_cull_classifier.sv @@
// frustum_cull_classifier: top level, joins controller and datapath
// depends on frc_pkg, frc_ctrl, frc_dp
//
// command channel: a word is taken at a rising edge with start high and
// busy low; i_func selects load plane, classify point, classify sphere,
// load box half-axis or classify box, i_slot picks the plane or axis
// result channel: o_done is high for exactly one cycle with o_position
// valid in that cycle; the receiver cannot hold results off
// load plane completes at the accept edge and busy stays low
// load half-axis: busy until the datapath has drained, no result
// point and sphere: one plane issued per cycle through the four-lane dot
// product unit, result once a plane decides, busy until the result cycle
// box: four dot products per plane (three half-axes, then the center)
// share the same unit, result once a plane's center product decides
// codes 5 to 7 and out-of-range slots are taken and dropped
// reset (synchronous, active low) returns to idle and drops any job;
// plane and axis entries hold garbage until loaded
module frustum_cull_classifier
    import frc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [2:0]               i_func,
    input  logic [2:0]               i_slot,
    input  logic signed [COMP_W-1:0] i_px,
    input  logic signed [COMP_W-1:0] i_py,
    input  logic signed [COMP_W-1:0] i_pz,
    input  logic signed [COMP_W-1:0] i_pw,
    output logic                     o_done,
    output logic [1:0]               o_position
);

    t_cmd    cmd;
    t_status status;

    frc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_func     (i_func),
        .i_slot     (i_slot),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_busy     (busy),
        .o_done     (o_done),
        .o_position (o_position)
    );

    frc_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_func   (i_func),
        .i_slot   (i_slot),
        .i_px     (i_px),
        .i_py     (i_py),
        .i_pz     (i_pz),
        .i_pw     (i_pw),
        .o_status (status)
    );

    // a result only closes a running job
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without a job");

    // one result per job
    a_single_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result repeated");

    // plane loads never occupy the block
    a_plane_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_func == FN_LOAD_PLANE)) |=> !busy)
        else $error("plane load started a job");

    // the datapath is empty whenever the block is idle
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !$past(busy)) |-> status.empty)
        else $error("work in flight while idle");

endmodule
